### design/q2e_pkg.sv
// ============================================================================
// q2e_pkg: shared types and constants for the quaternion to Euler converter
// Item structs, fixed-point widths and the CORDIC arctangent table.
// ============================================================================
`default_nettype none

package q2e_pkg;

  // Field and fraction widths
  localparam int DataWidth   = 16;              // Q3.13 in and out
  localparam int CordicSteps = 16;              // default CORDIC length
  localparam int ThrWidth    = 20;              // threshold, unsigned Q0.20
  localparam int FracBits    = 20;              // pitch sine, Q0.20
  localparam int QueueDepth  = 4;

  localparam logic [ThrWidth-1:0] ThrReset = {ThrWidth{1'b1}};

  // Derived widths
  localparam int ProdW     = 2 * DataWidth;     // one component product
  localparam int CordIn    = 2 * DataWidth + 2; // atan2 operand
  localparam int NormW     = 2 * DataWidth + 1; // sum of squares
  localparam int QuotW     = FracBits + 1;      // |sine| up to 1.0
  localparam int SineW     = FracBits + 2;      // signed sine
  localparam int DivW      = NormW + FracBits;  // divider remainder
  localparam int AngW      = 36;                // Q30 angle accumulator
  localparam int NormBit   = 40;                // CORDIC operand scale 2^40
  localparam int NormStages = $clog2(NormBit + 1);
  localparam int CordW     = ((CordIn > NormBit + 1) ? CordIn : NormBit + 1) + 4;
  localparam int SqrtSteps = NormBit / 2 + 1;
  localparam int SqrtW     = NormBit + 2;
  localparam int OutShift  = 30 - (DataWidth - 3);

  localparam logic signed [AngW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 36'sd1686629713;

  typedef enum logic [1:0] {
    POLE_NONE = 2'd0,
    POLE_NEG  = 2'd1,
    POLE_POS  = 2'd2
  } pole_e;

  // Input item
  typedef struct packed {
    logic signed [DataWidth-1:0] quat_w;
    logic signed [DataWidth-1:0] quat_x;
    logic signed [DataWidth-1:0] quat_y;
    logic signed [DataWidth-1:0] quat_z;
  } quat_t;

  // Result item
  typedef struct packed {
    logic signed [DataWidth-1:0] roll_angle;
    logic signed [DataWidth-1:0] pitch_angle;
    logic signed [DataWidth-1:0] yaw_angle;
    pole_e                       pole_case;
    logic                        zero_norm;
  } euler_t;

  // Classified item, front to back
  typedef struct packed {
    logic signed [SineW-1:0]  sine;
    pole_e                    pole_case;
    logic                     zero_norm;
    logic signed [CordIn-1:0] roll_y;
    logic signed [CordIn-1:0] roll_x;
    logic signed [CordIn-1:0] yaw_y;
    logic signed [CordIn-1:0] yaw_x;
  } mid_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [AngW-1:0] atan_q30(input int unsigned i);
    logic signed [AngW-1:0] v;
    case (i)
      0:  v = 36'sd843314856;
      1:  v = 36'sd497837829;
      2:  v = 36'sd263043836;
      3:  v = 36'sd133525158;
      4:  v = 36'sd67021686;
      5:  v = 36'sd33543515;
      6:  v = 36'sd16775850;
      7:  v = 36'sd8388437;
      8:  v = 36'sd4194282;
      9:  v = 36'sd2097149;
      10: v = 36'sd1048575;
      11: v = 36'sd524287;
      default: begin
        if (i < 30) v = (AngW'(1) <<< (30 - i)) - AngW'(1);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/q2e_fifo.sv
// ============================================================================
// q2e_fifo: small register queue
// Holds items between pipeline sections; read data is the head entry.
// ============================================================================
`default_nettype none

module q2e_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = q2e_pkg::QueueDepth
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   push_i,
  input  item_t wdata_i,
  output logic  full_o,
  input  wire   pop_i,
  output item_t rdata_o,
  output logic  empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH)) else $error("queue count past depth");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |=> !empty_o) else $error("queue empty after push");

  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push && cnt_q == CW'(1)) |=> empty_o)
    else $error("queue not empty after last pop");

endmodule

`default_nettype wire

### design/q2e_front.sv
// ============================================================================
// q2e_front: product, norm and pitch-sine divider section
// Forms the quaternion products, divides for the pitch sine and classifies
// each item as normal, lower pole or upper pole.
// ============================================================================
`default_nettype none

module q2e_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  q2e_pkg::quat_t        quat_i,
  output logic                  in_ready_o,
  input  wire                   cfg_we_i,
  input  wire [q2e_pkg::ThrWidth-1:0] cfg_wdata_i,
  input  wire                   mid_full_i,
  output logic                  mid_push_o,
  output q2e_pkg::mid_t         mid_o
);

  import q2e_pkg::*;

  typedef struct packed {
    logic [NormW-1:0]            norm;
    logic                        neg;
    logic                        zero;
    logic signed [CordIn-1:0]    roll_y;
    logic signed [CordIn-1:0]    roll_x;
    logic signed [CordIn-1:0]    yaw_y;
    logic signed [CordIn-1:0]    yaw_x;
    logic signed [DataWidth-1:0] raw_x;
    logic signed [DataWidth-1:0] raw_y;
  } side_t;

  logic en;
  logic [ThrWidth-1:0] thr_q;

  // Product stage
  logic signed [ProdW-1:0] pww_q, pxx_q, pyy_q, pzz_q, pwy_q;
  logic signed [ProdW-1:0] pxz_q, pyz_q, pwx_q, pxy_q, pwz_q;
  logic signed [DataWidth-1:0] rx_q, ry_q;
  logic f1_vld_q;

  // Divider stages, index 0 is the sum stage
  side_t            side_q [QuotW+1];
  logic [DivW-1:0]  rem_q  [QuotW+1];
  logic [QuotW-1:0] quo_q  [QuotW+1];
  logic             dvld_q [QuotW+1];

  logic signed [CordIn-1:0] f2_num, f2_abs;
  side_t f2_side;

  assign en         = !(dvld_q[QuotW] && mid_full_i);
  assign in_ready_o = en;
  assign mid_push_o = en && dvld_q[QuotW];

  // Pole threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q  <= 1'b0;
      dvld_q[0] <= 1'b0;
    end else if (en) begin
      f1_vld_q  <= in_valid_i;
      dvld_q[0] <= f1_vld_q;
    end
  end

  // Component products
  always_ff @(posedge clk_i) begin
    if (en) begin
      pww_q <= quat_i.quat_w * quat_i.quat_w;
      pxx_q <= quat_i.quat_x * quat_i.quat_x;
      pyy_q <= quat_i.quat_y * quat_i.quat_y;
      pzz_q <= quat_i.quat_z * quat_i.quat_z;
      pwy_q <= quat_i.quat_w * quat_i.quat_y;
      pxz_q <= quat_i.quat_x * quat_i.quat_z;
      pyz_q <= quat_i.quat_y * quat_i.quat_z;
      pwx_q <= quat_i.quat_w * quat_i.quat_x;
      pxy_q <= quat_i.quat_x * quat_i.quat_y;
      pwz_q <= quat_i.quat_w * quat_i.quat_z;
      rx_q  <= quat_i.quat_x;
      ry_q  <= quat_i.quat_y;
    end
  end

  // Sums: norm, sine numerator and the atan2 operands
  always_comb begin
    f2_num = (CordIn'(pwy_q) - CordIn'(pxz_q)) <<< 1;
    f2_abs = f2_num[CordIn-1] ? -f2_num : f2_num;
    f2_side.norm = NormW'($unsigned(pww_q)) + NormW'($unsigned(pxx_q))
                 + NormW'($unsigned(pyy_q)) + NormW'($unsigned(pzz_q));
    f2_side.neg    = f2_num[CordIn-1];
    f2_side.zero   = (f2_side.norm == '0);
    f2_side.roll_y = (CordIn'(pyz_q) + CordIn'(pwx_q)) <<< 1;
    f2_side.roll_x = CordIn'(pww_q) - CordIn'(pxx_q) - CordIn'(pyy_q) + CordIn'(pzz_q);
    f2_side.yaw_y  = (CordIn'(pxy_q) + CordIn'(pwz_q)) <<< 1;
    f2_side.yaw_x  = CordIn'(pww_q) + CordIn'(pxx_q) - CordIn'(pyy_q) - CordIn'(pzz_q);
    f2_side.raw_x  = rx_q;
    f2_side.raw_y  = ry_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= f2_side;
      rem_q[0]  <= DivW'(f2_abs[NormW-1:0]) << FracBits;
      quo_q[0]  <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QuotW; k++) begin : g_div
    localparam int J = QuotW - 1 - k;
    logic [DivW-1:0] dsub;
    assign dsub = DivW'(side_q[k].norm) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvld_q[k+1] <= 1'b0;
      end else if (en) begin
        dvld_q[k+1] <= dvld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k+1] <= side_q[k];
        if (rem_q[k] >= dsub) begin
          rem_q[k+1] <= rem_q[k] - dsub;
          quo_q[k+1] <= quo_q[k] | (QuotW'(1) << J);
        end else begin
          rem_q[k+1] <= rem_q[k];
          quo_q[k+1] <= quo_q[k];
        end
      end
    end
  end

  // Pole classification
  logic signed [SineW-1:0] s_mag, sine, thr_s;
  side_t last;

  always_comb begin
    last  = side_q[QuotW];
    s_mag = $signed({1'b0, quo_q[QuotW]});
    sine  = last.neg ? -s_mag : s_mag;
    thr_s = $signed({2'b00, thr_q});

    mid_o.sine      = sine;
    mid_o.zero_norm = last.zero;
    mid_o.roll_y    = last.roll_y;
    mid_o.roll_x    = last.roll_x;
    if (last.zero) mid_o.pole_case = POLE_NONE;
    else if (sine <= -thr_s) mid_o.pole_case = POLE_NEG;
    else if (sine >= thr_s) mid_o.pole_case = POLE_POS;
    else mid_o.pole_case = POLE_NONE;

    // at a pole yaw comes from atan2(y, x) of the raw components
    if (mid_o.pole_case != POLE_NONE) begin
      mid_o.yaw_y = CordIn'(last.raw_y);
      mid_o.yaw_x = CordIn'(last.raw_x);
    end else begin
      mid_o.yaw_y = last.yaw_y;
      mid_o.yaw_x = last.yaw_x;
    end
  end

endmodule

`default_nettype wire

### design/q2e_cordic.sv
// ============================================================================
// q2e_cordic: pipelined vectoring CORDIC for atan2
// Quadrant fold, operand normalize and one rotation per stage, Q30 angle.
// ============================================================================
`default_nettype none

module q2e_cordic #(
  parameter int STEPS = q2e_pkg::CordicSteps
) (
  input  wire                                clk_i,
  input  wire                                en_i,
  input  wire signed [q2e_pkg::CordIn-1:0]   y_i,
  input  wire signed [q2e_pkg::CordIn-1:0]   x_i,
  output logic signed [q2e_pkg::AngW-1:0]    angle_o
);

  import q2e_pkg::*;

  localparam int L = 1 + NormStages + STEPS;

  logic signed [CordW-1:0] x_q [L];
  logic signed [CordW-1:0] y_q [L];
  logic signed [AngW-1:0]  a_q [L];
  logic                    z_q [L];

  function automatic logic [CordW-1:0] mag(input logic signed [CordW-1:0] v);
    return v[CordW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  assign angle_o = z_q[L-1] ? '0 : a_q[L-1];

  for (genvar k = 0; k < L; k++) begin : g_stage
    if (k == 0) begin : g_prep
      // fold the left half plane by pi
      logic signed [CordW-1:0] xe, ye;
      assign xe = CordW'(x_i);
      assign ye = CordW'(y_i);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[0] <= (xe == '0) && (ye == '0);
          if (xe < 0) begin
            x_q[0] <= -xe;
            y_q[0] <= -ye;
            a_q[0] <= (ye >= 0) ? PiQ30 : -PiQ30;
          end else begin
            x_q[0] <= xe;
            y_q[0] <= ye;
            a_q[0] <= '0;
          end
        end
      end
    end else if (k <= NormStages) begin : g_norm
      // scale both operands up until one reaches 2^40
      localparam int Sh = 1 << (NormStages - k);
      logic [CordW-1:0] lim;
      assign lim = CordW'(1) << (NormBit + 1 - Sh);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[k] <= z_q[k-1];
          a_q[k] <= a_q[k-1];
          if (mag(x_q[k-1]) < lim && mag(y_q[k-1]) < lim) begin
            x_q[k] <= x_q[k-1] <<< Sh;
            y_q[k] <= y_q[k-1] <<< Sh;
          end else begin
            x_q[k] <= x_q[k-1];
            y_q[k] <= y_q[k-1];
          end
        end
      end
    end else begin : g_rot
      localparam int I = k - 1 - NormStages;
      logic signed [CordW-1:0] xs, ys;
      assign xs = x_q[k-1] >>> I;
      assign ys = y_q[k-1] >>> I;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[k] <= z_q[k-1];
          if (y_q[k-1] >= 0) begin
            x_q[k] <= x_q[k-1] + ys;
            y_q[k] <= y_q[k-1] - xs;
            a_q[k] <= a_q[k-1] + atan_q30(I);
          end else begin
            x_q[k] <= x_q[k-1] - ys;
            y_q[k] <= y_q[k-1] + xs;
            a_q[k] <= a_q[k-1] - atan_q30(I);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/q2e_back.sv
// ============================================================================
// q2e_back: square root and angle section
// Forms the pitch cosine, runs the three atan2 pipelines and rounds the
// angles into the result item.
// ============================================================================
`default_nettype none

module q2e_back #(
  parameter int STEPS = q2e_pkg::CordicSteps
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              mid_empty_i,
  input  q2e_pkg::mid_t    mid_i,
  output logic             mid_pop_o,
  input  wire              out_full_i,
  output logic             out_push_o,
  output q2e_pkg::euler_t  out_o
);

  import q2e_pkg::*;

  localparam int CordLat = 1 + NormStages + STEPS;
  localparam logic signed [AngW:0] OutHi = (AngW+1)'((2 ** (DataWidth - 1)) - 1);
  localparam logic signed [AngW:0] OutLo = -(AngW+1)'(2 ** (DataWidth - 1));

  logic en;

  // Square-root stages, index 0 holds 1 - s^2
  mid_t             b_rec_q  [SqrtSteps+1];
  logic [SqrtW-1:0] b_rem_q  [SqrtSteps+1];
  logic [SqrtW-1:0] b_root_q [SqrtSteps+1];
  logic             b_vld_q  [SqrtSteps+1];

  // Side data alongside the CORDIC pipelines
  logic  c_vld_q  [CordLat];
  pole_e c_pole_q [CordLat];
  logic  c_zero_q [CordLat];

  logic signed [2*SineW-1:0] s_sq;
  logic signed [CordIn-1:0]  pit_y, pit_x;
  logic signed [AngW-1:0]    roll_a, pitch_a, yaw_a;

  function automatic logic signed [DataWidth-1:0] to_out(input logic signed [AngW:0] v);
    logic signed [AngW:0] r;
    r = (v + (AngW+1)'(1 << (OutShift - 1))) >>> OutShift;
    if (r > OutHi) r = OutHi;
    if (r < OutLo) r = OutLo;
    return $signed(r[DataWidth-1:0]);
  endfunction

  assign en         = !(c_vld_q[CordLat-1] && out_full_i);
  assign mid_pop_o  = en && !mid_empty_i;
  assign out_push_o = en && c_vld_q[CordLat-1];
  assign s_sq       = mid_i.sine * mid_i.sine;

  // Entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q[0] <= 1'b0;
    end else if (en) begin
      b_vld_q[0] <= mid_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_rec_q[0]  <= mid_i;
      b_rem_q[0]  <= (SqrtW'(1) << NormBit) - s_sq[SqrtW-1:0];
      b_root_q[0] <= '0;
    end
  end

  // Floor square root, one result bit per stage
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic [SqrtW-1:0] bitv, tst;
    assign bitv = SqrtW'(1) << (NormBit - 2 * k);
    assign tst  = b_root_q[k] + bitv;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_vld_q[k+1] <= 1'b0;
      end else if (en) begin
        b_vld_q[k+1] <= b_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        b_rec_q[k+1] <= b_rec_q[k];
        if (b_rem_q[k] >= tst) begin
          b_rem_q[k+1]  <= b_rem_q[k] - tst;
          b_root_q[k+1] <= (b_root_q[k] >> 1) + bitv;
        end else begin
          b_rem_q[k+1]  <= b_rem_q[k];
          b_root_q[k+1] <= b_root_q[k] >> 1;
        end
      end
    end
  end

  // asin(s) = atan2(s, sqrt(1 - s^2))
  assign pit_y = CordIn'(b_rec_q[SqrtSteps].sine);
  assign pit_x = $signed({{(CordIn - QuotW){1'b0}}, b_root_q[SqrtSteps][QuotW-1:0]});

  q2e_cordic #(.STEPS(STEPS)) u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (b_rec_q[SqrtSteps].roll_y),
    .x_i     (b_rec_q[SqrtSteps].roll_x),
    .angle_o (roll_a)
  );

  q2e_cordic #(.STEPS(STEPS)) u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (pit_y),
    .x_i     (pit_x),
    .angle_o (pitch_a)
  );

  q2e_cordic #(.STEPS(STEPS)) u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_i     (b_rec_q[SqrtSteps].yaw_y),
    .x_i     (b_rec_q[SqrtSteps].yaw_x),
    .angle_o (yaw_a)
  );

  // Side pipeline matching the CORDIC latency
  for (genvar k = 0; k < CordLat; k++) begin : g_side
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) c_vld_q[0] <= 1'b0;
        else if (en) c_vld_q[0] <= b_vld_q[SqrtSteps];
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          c_pole_q[0] <= b_rec_q[SqrtSteps].pole_case;
          c_zero_q[0] <= b_rec_q[SqrtSteps].zero_norm;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) c_vld_q[k] <= 1'b0;
        else if (en) c_vld_q[k] <= c_vld_q[k-1];
      end
      always_ff @(posedge clk_i) begin
        if (en) begin
          c_pole_q[k] <= c_pole_q[k-1];
          c_zero_q[k] <= c_zero_q[k-1];
        end
      end
    end
  end

  // Result assembly
  logic signed [AngW:0] yaw_w, yaw_2;
  always_comb begin
    yaw_w = (AngW+1)'(yaw_a);
    yaw_2 = yaw_w <<< 1;
    out_o.pole_case = c_pole_q[CordLat-1];
    out_o.zero_norm = c_zero_q[CordLat-1];
    if (c_zero_q[CordLat-1]) begin
      out_o.roll_angle  = '0;
      out_o.pitch_angle = '0;
      out_o.yaw_angle   = '0;
    end else begin
      unique case (c_pole_q[CordLat-1])
        POLE_NEG: begin
          out_o.roll_angle  = '0;
          out_o.pitch_angle = to_out(-(AngW+1)'(HalfPiQ30));
          out_o.yaw_angle   = to_out(-yaw_2);
        end
        POLE_POS: begin
          out_o.roll_angle  = '0;
          out_o.pitch_angle = to_out((AngW+1)'(HalfPiQ30));
          out_o.yaw_angle   = to_out(yaw_2);
        end
        default: begin
          out_o.roll_angle  = to_out((AngW+1)'(roll_a));
          out_o.pitch_angle = to_out((AngW+1)'(pitch_a));
          out_o.yaw_angle   = to_out(yaw_w);
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/quaternion_to_euler.sv
// ============================================================================
// quaternion_to_euler: quaternion to roll, pitch and yaw converter
// Q3.13 quaternion in, Q3.13 Euler angles out, with pole and zero flags.
// ============================================================================
// Throughput: one item per cycle while neither the middle nor the output queue is full.
// Path from accept to the output queue: the product and sum stages, the
//   21-stage sine divider, the middle queue, the 22-stage square root and
//   the 7 + CORDIC_STEPS CORDIC stages.
// The front stalls only when the middle queue is full, the back only when the
//   output queue is full.
// Reset: queues and pipelines empty, pole_threshold back to 1048575.
`default_nettype none

module quaternion_to_euler #(
  parameter int CORDIC_STEPS = q2e_pkg::CordicSteps
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          push,
  input  q2e_pkg::quat_t               quat_i,
  output logic                         full,
  input  wire                          pop,
  output q2e_pkg::euler_t              euler_o,
  output logic                         empty,
  input  wire                          cfg_we_i,
  input  wire [q2e_pkg::ThrWidth-1:0]  cfg_wdata_i
);

  import q2e_pkg::*;

  logic   in_ready;
  logic   mid_push, mid_full, mid_pop, mid_empty;
  mid_t   mid_wdata, mid_rdata;
  logic   out_push, out_full;
  euler_t out_wdata;

  assign full = !in_ready;

  q2e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .quat_i      (quat_i),
    .in_ready_o  (in_ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mid_full_i  (mid_full),
    .mid_push_o  (mid_push),
    .mid_o       (mid_wdata)
  );

  q2e_fifo #(.item_t(mid_t), .DEPTH(QueueDepth)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  q2e_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_i       (mid_rdata),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_o       (out_wdata)
  );

  q2e_fifo #(.item_t(euler_t), .DEPTH(QueueDepth)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (euler_o),
    .empty_o (empty)
  );

  a_zero_angles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && euler_o.zero_norm) |->
      (euler_o.roll_angle == '0 && euler_o.pitch_angle == '0 &&
       euler_o.yaw_angle == '0 && euler_o.pole_case == POLE_NONE))
    else $error("zero-norm item with nonzero angles");

  a_pole_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && euler_o.pole_case != POLE_NONE) |->
      (euler_o.roll_angle == '0 && !euler_o.zero_norm))
    else $error("pole item with nonzero roll");

  a_pole_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (euler_o.pole_case == POLE_NONE || euler_o.pole_case == POLE_NEG ||
                euler_o.pole_case == POLE_POS))
    else $error("pole code out of range");

endmodule

`default_nettype wire
